// ===== hdl/tgad_pkg.sv =====
// shared types and constants for the tga truecolor stream decoder
package tgad_pkg;

	// result kinds as seen on the kind port
	typedef enum logic [1:0] {
		KIND_PIXEL     = 2'd0,
		KIND_HEADER    = 2'd1,
		KIND_BAD_TYPE  = 2'd2,
		KIND_BAD_DEPTH = 2'd3
	} kind_t;

	// parser phases, one-hot
	typedef enum logic [4:0] {
		PH_IDLE   = 5'b00001,
		PH_HEADER = 5'b00010,
		PH_SKIP   = 5'b00100,
		PH_PIXELS = 5'b01000,
		PH_DONE   = 5'b10000
	} phase_t;

	// header byte positions
	localparam logic [4:0] HIDX_ID_LEN   = 5'd0;
	localparam logic [4:0] HIDX_MAP_TYPE = 5'd1;
	localparam logic [4:0] HIDX_TYPE     = 5'd2;
	localparam logic [4:0] HIDX_WIDTH_LO = 5'd12;
	localparam logic [4:0] HIDX_WIDTH_HI = 5'd13;
	localparam logic [4:0] HIDX_HEIGHT_LO = 5'd14;
	localparam logic [4:0] HIDX_HEIGHT_HI = 5'd15;
	localparam logic [4:0] HIDX_DEPTH    = 5'd16;
	localparam logic [4:0] HIDX_LAST     = 5'd17;

	localparam logic [7:0] TYPE_TRUECOLOR = 8'd2;
	localparam logic [7:0] MAP_NONE       = 8'd0;
	localparam logic [7:0] DEPTH_RGB      = 8'd24;
	localparam logic [7:0] DEPTH_RGBA     = 8'd32;
	localparam logic [7:0] FULL_ALPHA     = 8'hFF;

	// parser state
	typedef struct packed {
		phase_t      phase;
		logic [4:0]  header_index;
		logic [7:0]  id_length;
		logic [7:0]  map_type;
		logic [7:0]  type_code;
		logic [15:0] width_value;
		logic [15:0] height_value;
		logic [7:0]  depth_value;
		logic        has_alpha;
		logic [7:0]  skip_left;
		logic [1:0]  byte_in_pixel;
		logic [23:0] pixel_bytes;
		logic [15:0] column;
		logic [15:0] row;
	} parse_t;

	// parser state after reset: idle, everything else cleared
	localparam parse_t PARSE_RESET = '{phase: PH_IDLE, default: '0};

	// one result item
	typedef struct packed {
		kind_t       kind;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  alpha;
		logic [15:0] image_width;
		logic [15:0] image_height;
		logic        last;
	} result_t;

endpackage

// ===== hdl/tga_truecolor_stream_decoder_core.sv =====
// top level of the tga uncompressed truecolor stream decoder
//
// byte-wide tga parser: takes one file byte per transfer on the input channel and
// can accept a byte in every clock cycle. a byte with start_of_file set restarts
// parsing as header byte 0. the 18-byte header gives one result (header accepted
// with width and height, or an unsupported type / depth error), then the id field
// is skipped and each 3 or 4 pixel bytes (b,g,r[,a]) give one rgba pixel result,
// with last set on the final pixel. when the output buffer is empty, a result
// appears on the output port in the cycle after the byte that completes it is
// accepted. results go through a two-entry output buffer, so input keeps flowing
// while a result waits on out_ready; in_ready drops only when both entries hold
// results. all per-byte work is one pass of counters and compares between the
// parser state registers and the output buffer.
module tga_truecolor_stream_decoder_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        start_of_file,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic [7:0]  alpha,
	output logic [15:0] image_width,
	output logic [15:0] image_height,
	output logic        last
);

	tgad_pkg::parse_t  parse_q;
	tgad_pkg::parse_t  cur;
	tgad_pkg::parse_t  nxt;
	tgad_pkg::result_t res;
	logic              produce;

	// output buffer: head drives the ports, skid catches a result during a stall
	tgad_pkg::result_t head_q;
	tgad_pkg::result_t skid_q;
	logic              head_valid_q;
	logic              skid_valid_q;

	logic accept;
	logic push;
	logic pop;

	assign in_ready = ~skid_valid_q;
	assign accept   = in_valid & in_ready;
	assign push     = accept & produce;
	assign pop      = head_valid_q & out_ready;

	// per-byte parser step
	always_comb begin
		logic [16:0] col_inc;
		logic        empty;
		logic        is_last;
		logic [1:0]  need;

		cur = parse_q;
		if (start_of_file) begin
			// fresh file: clear everything, this byte is header byte 0
			cur = '0;
			cur.phase = tgad_pkg::PH_HEADER;
		end

		nxt     = cur;
		produce = 1'b0;
		res     = '0;
		res.kind = tgad_pkg::KIND_PIXEL;

		col_inc = {1'b0, cur.column} + 17'd1;
		empty   = (cur.width_value == 16'd0) || (cur.height_value == 16'd0);
		is_last = (cur.column == cur.width_value - 16'd1) &&
			(cur.row == cur.height_value - 16'd1);
		need    = cur.has_alpha ? 2'd3 : 2'd2;

		case (cur.phase)
			tgad_pkg::PH_HEADER: begin
				nxt.header_index = cur.header_index + 5'd1;
				case (cur.header_index)
					tgad_pkg::HIDX_ID_LEN:    nxt.id_length = data_byte;
					tgad_pkg::HIDX_MAP_TYPE:  nxt.map_type = data_byte;
					tgad_pkg::HIDX_TYPE:      nxt.type_code = data_byte;
					tgad_pkg::HIDX_WIDTH_LO:  nxt.width_value[7:0] = data_byte;
					tgad_pkg::HIDX_WIDTH_HI:  nxt.width_value[15:8] = data_byte;
					tgad_pkg::HIDX_HEIGHT_LO: nxt.height_value[7:0] = data_byte;
					tgad_pkg::HIDX_HEIGHT_HI: nxt.height_value[15:8] = data_byte;
					tgad_pkg::HIDX_DEPTH:     nxt.depth_value = data_byte;
					default: ;
				endcase
				if (cur.header_index == tgad_pkg::HIDX_LAST) begin
					produce = 1'b1;
					if (cur.type_code != tgad_pkg::TYPE_TRUECOLOR ||
						cur.map_type != tgad_pkg::MAP_NONE) begin
						// type check wins when both are wrong
						nxt.phase = tgad_pkg::PH_DONE;
						res.kind  = tgad_pkg::KIND_BAD_TYPE;
						res.last  = 1'b1;
					end else if (!(cur.depth_value inside
						{tgad_pkg::DEPTH_RGB, tgad_pkg::DEPTH_RGBA})) begin
						nxt.phase = tgad_pkg::PH_DONE;
						res.kind  = tgad_pkg::KIND_BAD_DEPTH;
						res.last  = 1'b1;
					end else begin
						nxt.has_alpha = (cur.depth_value == tgad_pkg::DEPTH_RGBA);
						if (empty) begin
							nxt.phase = tgad_pkg::PH_DONE;
						end else if (cur.id_length != 8'd0) begin
							nxt.skip_left = cur.id_length;
							nxt.phase     = tgad_pkg::PH_SKIP;
						end else begin
							nxt.phase = tgad_pkg::PH_PIXELS;
						end
						res.kind         = tgad_pkg::KIND_HEADER;
						res.image_width  = cur.width_value;
						res.image_height = cur.height_value;
						res.last         = empty;
					end
				end
			end
			tgad_pkg::PH_SKIP: begin
				nxt.skip_left = cur.skip_left - 8'd1;
				if (cur.skip_left == 8'd1) begin
					nxt.phase = tgad_pkg::PH_PIXELS;
				end
			end
			tgad_pkg::PH_PIXELS: begin
				if (cur.byte_in_pixel < need) begin
					// gather b, g and (for 32-bit) r
					case (cur.byte_in_pixel)
						2'd0:    nxt.pixel_bytes[7:0]   = data_byte;
						2'd1:    nxt.pixel_bytes[15:8]  = data_byte;
						default: nxt.pixel_bytes[23:16] = data_byte;
					endcase
					nxt.byte_in_pixel = cur.byte_in_pixel + 2'd1;
				end else begin
					produce   = 1'b1;
					res.kind  = tgad_pkg::KIND_PIXEL;
					res.blue  = cur.pixel_bytes[7:0];
					res.green = cur.pixel_bytes[15:8];
					if (cur.has_alpha) begin
						res.red   = cur.pixel_bytes[23:16];
						res.alpha = data_byte;
					end else begin
						res.red   = data_byte;
						res.alpha = tgad_pkg::FULL_ALPHA;
					end
					res.last          = is_last;
					nxt.pixel_bytes   = '0;
					nxt.byte_in_pixel = 2'd0;
					// raster position, column wraps at the image width
					if (col_inc >= {1'b0, cur.width_value}) begin
						nxt.column = 16'd0;
						nxt.row    = cur.row + 16'd1;
					end else begin
						nxt.column = col_inc[15:0];
					end
					if (is_last) begin
						nxt.phase = tgad_pkg::PH_DONE;
					end
				end
			end
			default: ; // idle and done ignore bytes until the next start
		endcase
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parse_q <= tgad_pkg::PARSE_RESET;
		end else if (accept) begin
			parse_q <= nxt;
		end
	end

	// output buffer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			if (skid_valid_q) begin
				skid_valid_q <= push;
			end else begin
				head_valid_q <= push;
			end
		end else if (push) begin
			if (head_valid_q) begin
				skid_valid_q <= 1'b1;
			end else begin
				head_valid_q <= 1'b1;
			end
		end
	end

	// output buffer payload
	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q) begin
				head_q <= skid_q;
				if (push) begin
					skid_q <= res;
				end
			end else if (push) begin
				head_q <= res;
			end
		end else if (push) begin
			if (head_valid_q) begin
				skid_q <= res;
			end else begin
				head_q <= res;
			end
		end
	end

	assign out_valid    = head_valid_q;
	assign kind         = head_q.kind;
	assign red          = head_q.red;
	assign green        = head_q.green;
	assign blue         = head_q.blue;
	assign alpha        = head_q.alpha;
	assign image_width  = head_q.image_width;
	assign image_height = head_q.image_height;
	assign last         = head_q.last;

endmodule

// ===== hdl/tgad_checker.sv =====
// port-level checker for the tga decoder, bound to the top level
module tgad_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  kind,
	input logic [7:0]  red,
	input logic [7:0]  green,
	input logic [7:0]  blue,
	input logic [7:0]  alpha,
	input logic [15:0] image_width,
	input logic [15:0] image_height,
	input logic        last
);

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(last))
	else $error("result changed while stalled");

	// errors always end the file
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == tgad_pkg::KIND_BAD_TYPE || kind == tgad_pkg::KIND_BAD_DEPTH)
		|-> last)
	else $error("error result without last");

	// non-pixel results carry no color
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != tgad_pkg::KIND_PIXEL
		|-> red == 8'd0 && green == 8'd0 && blue == 8'd0 && alpha == 8'd0)
	else $error("color on a non-pixel result");

	// only header results carry the image size
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != tgad_pkg::KIND_HEADER
		|-> image_width == 16'd0 && image_height == 16'd0)
	else $error("size on a non-header result");

	// input is only held off while a result is waiting
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
	else $error("input stalled with no pending result");

endmodule

bind tga_truecolor_stream_decoder_core tgad_checker u_tgad_checker (.*);

// ===== dv/testbench.sv =====
// self-checking testbench for the tga truecolor stream decoder core
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	// clock and reset
	logic clk = 1'b0;
	logic arst_n = 1'b0;

	always #5 clk = ~clk;

	// input channel: one file byte per transfer
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = 8'd0;
	logic        start_of_file = 1'b0;

	// output channel: one decoded item per transfer
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  kind;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic [7:0]  alpha;
	logic [15:0] image_width;
	logic [15:0] image_height;
	logic        last;

	tga_truecolor_stream_decoder_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_byte    (data_byte),
		.start_of_file(start_of_file),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.kind         (kind),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.alpha        (alpha),
		.image_width  (image_width),
		.image_height (image_height),
		.last         (last)
	);

	// idle / stall odds in percent, changed between test phases
	int in_idle_pct = 0;
	int out_stall_pct = 0;

	int mismatch_count = 0;
	int bytes_sent = 0;

	// decoded items predicted but not yet seen on the output, oldest first
	tgad_pkg::result_t decoded_items[$];

	// bytes of the file currently being built for sending
	logic [7:0] file_bytes[$];

	// parser state mirror used for prediction
	tgad_pkg::phase_t tga_phase;
	logic [4:0]  tga_hidx;
	logic [7:0]  tga_id_len;
	logic [7:0]  tga_map;
	logic [7:0]  tga_type;
	logic [7:0]  tga_depth;
	logic [15:0] tga_width;
	logic [15:0] tga_height;
	logic        tga_alpha;
	logic [7:0]  tga_skip;
	logic [1:0]  tga_nbytes;
	logic [23:0] tga_pix;
	logic [15:0] tga_col;
	logic [15:0] tga_row;

	function automatic void clear_parse_state();
		tga_hidx   = '0;
		tga_id_len = '0;
		tga_map    = '0;
		tga_type   = '0;
		tga_depth  = '0;
		tga_width  = '0;
		tga_height = '0;
		tga_alpha  = 1'b0;
		tga_skip   = '0;
		tga_nbytes = '0;
		tga_pix    = '0;
		tga_col    = '0;
		tga_row    = '0;
	endfunction

	// advance the parser mirror by one accepted byte, queue any decoded item
	function automatic void decode_tga_byte(input logic [7:0] b, input logic sof);
		tgad_pkg::result_t item;
		logic [4:0] idx;
		logic [1:0] need;
		logic       is_empty;
		logic       is_last;
		item = '0;
		// a start mark restarts parsing with this byte as header byte 0
		if (sof) begin
			clear_parse_state();
			tga_phase = tgad_pkg::PH_HEADER;
		end
		case (tga_phase)
			tgad_pkg::PH_HEADER: begin
				idx = tga_hidx;
				tga_hidx = tga_hidx + 5'd1;
				case (idx)
					tgad_pkg::HIDX_ID_LEN:    tga_id_len = b;
					tgad_pkg::HIDX_MAP_TYPE:  tga_map = b;
					tgad_pkg::HIDX_TYPE:      tga_type = b;
					tgad_pkg::HIDX_WIDTH_LO:  tga_width[7:0] = b;
					tgad_pkg::HIDX_WIDTH_HI:  tga_width[15:8] = b;
					tgad_pkg::HIDX_HEIGHT_LO: tga_height[7:0] = b;
					tgad_pkg::HIDX_HEIGHT_HI: tga_height[15:8] = b;
					tgad_pkg::HIDX_DEPTH:     tga_depth = b;
					default: ;
				endcase
				if (idx == tgad_pkg::HIDX_LAST) begin
					// type is checked before depth
					if (tga_type != tgad_pkg::TYPE_TRUECOLOR ||
						tga_map != tgad_pkg::MAP_NONE) begin
						tga_phase = tgad_pkg::PH_DONE;
						item.kind = tgad_pkg::KIND_BAD_TYPE;
						item.last = 1'b1;
					end else if (!(tga_depth inside
						{tgad_pkg::DEPTH_RGB, tgad_pkg::DEPTH_RGBA})) begin
						tga_phase = tgad_pkg::PH_DONE;
						item.kind = tgad_pkg::KIND_BAD_DEPTH;
						item.last = 1'b1;
					end else begin
						tga_alpha = (tga_depth == tgad_pkg::DEPTH_RGBA);
						is_empty = (tga_width == 16'd0 || tga_height == 16'd0);
						if (is_empty)
							tga_phase = tgad_pkg::PH_DONE;
						else if (tga_id_len != 8'd0) begin
							tga_skip = tga_id_len;
							tga_phase = tgad_pkg::PH_SKIP;
						end else
							tga_phase = tgad_pkg::PH_PIXELS;
						item.kind = tgad_pkg::KIND_HEADER;
						item.image_width = tga_width;
						item.image_height = tga_height;
						item.last = is_empty;
					end
					decoded_items.push_back(item);
				end
			end
			tgad_pkg::PH_SKIP: begin
				tga_skip = tga_skip - 8'd1;
				if (tga_skip == 8'd0)
					tga_phase = tgad_pkg::PH_PIXELS;
			end
			tgad_pkg::PH_PIXELS: begin
				need = tga_alpha ? 2'd3 : 2'd2;
				if (tga_nbytes < need) begin
					tga_pix[tga_nbytes * 8 +: 8] = b;
					tga_nbytes = tga_nbytes + 2'd1;
				end else begin
					// stored order is b,g,r then a for 32-bit files
					item.kind  = tgad_pkg::KIND_PIXEL;
					item.blue  = tga_pix[7:0];
					item.green = tga_pix[15:8];
					item.red   = tga_alpha ? tga_pix[23:16] : b;
					item.alpha = tga_alpha ? b : tgad_pkg::FULL_ALPHA;
					tga_pix = '0;
					tga_nbytes = '0;
					is_last = (tga_col == tga_width - 16'd1) &&
						(tga_row == tga_height - 16'd1);
					if (int'(tga_col) + 1 >= int'(tga_width)) begin
						tga_col = '0;
						tga_row = tga_row + 16'd1;
					end else
						tga_col = tga_col + 16'd1;
					if (is_last)
						tga_phase = tgad_pkg::PH_DONE;
					item.last = is_last;
					decoded_items.push_back(item);
				end
			end
			default: ;
		endcase
	endfunction

	// one byte transfer on the input channel, with random idle cycles first
	task automatic send_byte(input logic [7:0] b, input logic sof);
		while ($urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		data_byte     <= b;
		start_of_file <= sof;
		do
			@(posedge clk);
		while (!in_ready);
		bytes_sent++;
		decode_tga_byte(b, sof);
	endtask

	// header plus id field plus n_body payload bytes, ignored header bytes random
	function automatic void build_file(input int id_len, input int map, input int typ,
		input int w, input int h, input int depth, input int n_body);
		file_bytes.delete();
		for (int i = 0; i <= tgad_pkg::HIDX_LAST; i++)
			file_bytes.push_back(8'($urandom_range(255)));
		file_bytes[tgad_pkg::HIDX_ID_LEN]    = id_len[7:0];
		file_bytes[tgad_pkg::HIDX_MAP_TYPE]  = map[7:0];
		file_bytes[tgad_pkg::HIDX_TYPE]      = typ[7:0];
		file_bytes[tgad_pkg::HIDX_WIDTH_LO]  = w[7:0];
		file_bytes[tgad_pkg::HIDX_WIDTH_HI]  = w[15:8];
		file_bytes[tgad_pkg::HIDX_HEIGHT_LO] = h[7:0];
		file_bytes[tgad_pkg::HIDX_HEIGHT_HI] = h[15:8];
		file_bytes[tgad_pkg::HIDX_DEPTH]     = depth[7:0];
		for (int i = 0; i < id_len + n_body; i++)
			file_bytes.push_back(8'($urandom_range(255)));
	endfunction

	function automatic int image_bytes(input int w, input int h, input int depth);
		return w * h * ((depth == tgad_pkg::DEPTH_RGBA) ? 4 : 3);
	endfunction

	// send the first n bytes of the built file, start mark on the first
	task automatic send_file(input int n);
		for (int i = 0; i < n; i++)
			send_byte(file_bytes[i], i == 0);
	endtask

	task automatic send_noise(input int n);
		for (int i = 0; i < n; i++)
			send_byte(8'($urandom_range(255)), 1'b0);
	endtask

	// bytes ahead of the first start mark
	task automatic test_before_start();
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_noise(2);
	endtask

	// wrong type code, colour map present, and both type and depth wrong
	task automatic test_bad_type();
		build_file(0, tgad_pkg::MAP_NONE, 1, 2, 2, tgad_pkg::DEPTH_RGB, 3);
		send_file(file_bytes.size());
		build_file(0, 1, tgad_pkg::TYPE_TRUECOLOR, 1, 1, tgad_pkg::DEPTH_RGBA, 4);
		send_file(file_bytes.size());
		build_file(3, 255, 255, 1, 1, 8, 0);
		send_file(file_bytes.size());
	endtask

	task automatic test_bad_depth();
		build_file(0, tgad_pkg::MAP_NONE, tgad_pkg::TYPE_TRUECOLOR, 1, 1, 16, 3);
		send_file(file_bytes.size());
		build_file(0, tgad_pkg::MAP_NONE, tgad_pkg::TYPE_TRUECOLOR, 1, 1, 255, 0);
		send_file(file_bytes.size());
	endtask

	// zero width or zero height, trailing bytes must be ignored
	task automatic test_empty_image();
		build_file(2, tgad_pkg::MAP_NONE, tgad_pkg::TYPE_TRUECOLOR, 0, 5,
			tgad_pkg::DEPTH_RGB, 4);
		send_file(file_bytes.size());
		build_file(0, tgad_pkg::MAP_NONE, tgad_pkg::TYPE_TRUECOLOR, 3, 0,
			tgad_pkg::DEPTH_RGBA, 2);
		send_file(file_bytes.size());
	endtask

	// 24-bit image with id field, then bytes after the final pixel
	task automatic test_rgb_image();
		build_file(2, tgad_pkg::MAP_NONE, tgad_pkg::TYPE_TRUECOLOR, 2, 2,
			tgad_pkg::DEPTH_RGB, image_bytes(2, 2, tgad_pkg::DEPTH_RGB) + 3);
		send_file(file_bytes.size());
	endtask

	task automatic test_rgba_image();
		build_file(0, tgad_pkg::MAP_NONE, tgad_pkg::TYPE_TRUECOLOR, 3, 1,
			tgad_pkg::DEPTH_RGBA, image_bytes(3, 1, tgad_pkg::DEPTH_RGBA));
		send_file(file_bytes.size());
	endtask

	// longest id field
	task automatic test_long_id();
		build_file(255, tgad_pkg::MAP_NONE, tgad_pkg::TYPE_TRUECOLOR, 1, 1,
			tgad_pkg::DEPTH_RGB, image_bytes(1, 1, tgad_pkg::DEPTH_RGB));
		send_file(file_bytes.size());
	endtask

	// restart in the header, in the id field and among the pixels
	task automatic test_restart();
		build_file(0, tgad_pkg::MAP_NONE, tgad_pkg::TYPE_TRUECOLOR, 1, 1,
			tgad_pkg::DEPTH_RGB, 3);
		send_file(7);
		build_file(255, tgad_pkg::MAP_NONE, tgad_pkg::TYPE_TRUECOLOR, 65535, 65535,
			tgad_pkg::DEPTH_RGBA, 0);
		send_file(24);
		build_file(0, tgad_pkg::MAP_NONE, tgad_pkg::TYPE_TRUECOLOR, 4, 4,
			tgad_pkg::DEPTH_RGB, image_bytes(4, 4, tgad_pkg::DEPTH_RGB));
		send_file(28);
		build_file(1, tgad_pkg::MAP_NONE, tgad_pkg::TYPE_TRUECOLOR, 1, 2,
			tgad_pkg::DEPTH_RGBA, image_bytes(1, 2, tgad_pkg::DEPTH_RGBA));
		send_file(file_bytes.size());
	endtask

	// mostly well-formed files with random content, plus broken files and noise
	task automatic run_random_files(input int budget);
		int stop_at;
		int pick;
		int w;
		int h;
		int depth;
		int id_len;
		stop_at = bytes_sent + budget;
		while (bytes_sent < stop_at) begin
			pick   = $urandom_range(99);
			w      = $urandom_range(1, 4);
			h      = $urandom_range(1, 3);
			depth  = $urandom_range(1) ? tgad_pkg::DEPTH_RGBA : tgad_pkg::DEPTH_RGB;
			id_len = ($urandom_range(19) == 0) ? $urandom_range(4, 40) : $urandom_range(0, 3);
			if (pick < 65) begin
				build_file(id_len, tgad_pkg::MAP_NONE, tgad_pkg::TYPE_TRUECOLOR, w, h,
					depth, image_bytes(w, h, depth) +
					(($urandom_range(3) == 0) ? $urandom_range(1, 4) : 0));
				send_file(file_bytes.size());
			end else if (pick < 75) begin
				// truncated, the next start cuts it short
				build_file(id_len, tgad_pkg::MAP_NONE, tgad_pkg::TYPE_TRUECOLOR, w, h,
					depth, image_bytes(w, h, depth));
				send_file($urandom_range(1, file_bytes.size() - 1));
			end else if (pick < 85) begin
				build_file(id_len,
					$urandom_range(1) ? int'(tgad_pkg::MAP_NONE) : $urandom_range(255),
					$urandom_range(1) ? int'(tgad_pkg::TYPE_TRUECOLOR) :
						$urandom_range(255),
					$urandom_range(65535), $urandom_range(65535),
					($urandom_range(2) == 0) ? $urandom_range(255) : depth,
					$urandom_range(6));
				send_file(file_bytes.size());
			end else if (pick < 93) begin
				if ($urandom_range(1))
					w = 0;
				else
					h = 0;
				build_file(id_len, tgad_pkg::MAP_NONE, tgad_pkg::TYPE_TRUECOLOR, w, h,
					depth, $urandom_range(4));
				send_file(file_bytes.size());
			end else begin
				// loose bytes, now and then with a stray start mark
				repeat ($urandom_range(1, 6))
					send_byte(8'($urandom_range(255)), $urandom_range(9) == 0);
			end
		end
	endtask

	task automatic check_field(input string fname, input int want_v, input int got_v);
		if (want_v != got_v) begin
			$error("%s: expected %0d, actual %0d", fname, want_v, got_v);
			mismatch_count++;
		end
	endtask

	// compare every output transfer with the oldest prediction, drive out_ready
	always @(posedge clk) begin : result_check
		tgad_pkg::result_t want;
		if (out_valid === 1'b1 && out_ready) begin
			if (decoded_items.size() == 0) begin
				$error("output transfer with nothing predicted: kind %0d", kind);
				mismatch_count++;
			end else begin
				want = decoded_items.pop_front();
				check_field("kind", int'(want.kind), int'(kind));
				check_field("red", want.red, red);
				check_field("green", want.green, green);
				check_field("blue", want.blue, blue);
				check_field("alpha", want.alpha, alpha);
				check_field("image_width", want.image_width, image_width);
				check_field("image_height", want.image_height, image_height);
				check_field("last", want.last, last);
			end
		end
		out_ready <= ($urandom_range(99) >= out_stall_pct);
	end

	initial begin
		tga_phase = tgad_pkg::PH_IDLE;
		clear_parse_state();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_before_start();
		test_bad_type();
		test_bad_depth();
		test_empty_image();
		test_rgb_image();
		test_rgba_image();
		test_long_id();
		test_restart();

		// random part in four idling phases
		in_idle_pct = 0;
		out_stall_pct = 0;
		run_random_files(50);
		in_idle_pct = 74;
		out_stall_pct = 0;
		run_random_files(50);
		in_idle_pct = 0;
		out_stall_pct = 74;
		run_random_files(50);
		in_idle_pct = 28;
		out_stall_pct = 28;
		run_random_files(50);
		in_valid <= 1'b0;

		// drain, then wait on to catch stray outputs
		while (decoded_items.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

	// hard stop in case a handshake hangs
	initial begin
		#10ms;
		$display("testbench NOT OK");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/tgad_pkg.sv
hdl/tga_truecolor_stream_decoder_core.sv
hdl/tgad_checker.sv
dv/testbench.sv
